### sv/signed_binary_to_decimal_ascii_assert.svh
// Assertion macros for the converter RTL.
// Needs nothing else; include it by its bare file name.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define SBDA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Checks that a condition in one cycle brings a result in the next.
`define SBDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `SBDA_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

### sv/sbda_pkg.sv
// Shared types, constants and the multiples table of the decimal converter.
// Used by the digit cells, the serializer and the top level.
`default_nettype none

package sbda_pkg;

  // Number of decimal positions that print; the top one takes the whole quotient.
  localparam int DECIMAL_DIGITS = 10;
  // Decimal positions that a 32-bit magnitude can occupy.
  localparam int MAG_DIGITS     = 10;
  // Highest position that can print; positions above it only accumulate.
  localparam int TOP_POS        = ((DECIMAL_DIGITS < MAG_DIGITS) ? DECIMAL_DIGITS
                                                                  : MAG_DIGITS) - 1;
  localparam int MAX_CHARS      = MAG_DIGITS + 1;
  localparam int CNT_W          = $clog2(MAX_CHARS + 1);
  localparam int POS_W          = $clog2(MAG_DIGITS);
  localparam int MULT_W         = 34;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;

  // Work item handed from cell to cell.
  typedef struct packed {
    logic [31:0]                 rest;
    logic [7:0]                  hi;
    logic                        nz;
    logic                        stream;
    logic [CNT_W-1:0]            n;
    logic [MAX_CHARS-1:0][7:0]   chars;
  } stage_t;

  typedef logic [MAG_DIGITS-1:0][9:0][MULT_W-1:0] mult_tbl_t;

  // Multiples m * 10^p for every position p and digit m.
  function automatic mult_tbl_t mult_table();
    mult_tbl_t         t;
    logic [MULT_W-1:0] w;
    w = MULT_W'(1);
    for (int p = 0; p < MAG_DIGITS; p++) begin
      for (int m = 0; m < 10; m++) begin
        t[p][m] = w * MULT_W'(m);
      end
      w = w * MULT_W'(10);
    end
    return t;
  endfunction

  localparam mult_tbl_t MULT = mult_table();

endpackage

`default_nettype wire

### sv/sbda_cell.sv
// One decimal position of the converter chain: extracts a digit and appends
// its character. Depends on sbda_pkg.
`default_nettype none

module sbda_cell import sbda_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [POS_W-1:0] pos_i,
  input  wire logic             valid_i,
  input  wire stage_t           data_i,
  output logic                  valid_o,
  output stage_t                data_o
);

  logic              valid_q;
  stage_t            data_q;
  stage_t            data_d;
  logic [3:0]        digit;
  logic [MULT_W-1:0] rest_w;
  logic [7:0]        hi_acc;
  logic [7:0]        ch;
  logic              nz_n;
  logic              emit;

  // Digit by comparing the remainder with the nine multiples of the weight.
  always_comb begin
    rest_w = {{(MULT_W-32){1'b0}}, data_i.rest};
    digit  = 4'd0;
    for (int m = 1; m < 10; m++) begin
      if (rest_w >= MULT[pos_i][m]) begin
        digit = 4'(m);
      end
    end
  end

  // Subtract, accumulate the high quotient and append the character.
  always_comb begin
    data_d      = data_i;
    data_d.rest = data_i.rest - MULT[pos_i][digit][31:0];
    hi_acc      = (data_i.hi << 3) + (data_i.hi << 1) + {4'd0, digit};
    nz_n        = data_i.nz | (digit != 4'd0);
    data_d.nz   = nz_n;
    ch          = CH_ZERO + {4'd0, digit};
    emit        = 1'b0;
    if (pos_i > POS_W'(TOP_POS)) begin
      data_d.hi = hi_acc;
    end else begin
      emit = nz_n || (pos_i == '0);
      if (pos_i == POS_W'(TOP_POS)) begin
        ch = CH_ZERO + hi_acc;
      end
    end
    if (emit && (data_i.n < CNT_W'(MAX_CHARS))) begin
      data_d.chars[data_i.n] = ch;
      data_d.n               = data_i.n + CNT_W'(1);
    end
  end

  // Valid bit of the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Work item of the cell.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### sv/sbda_serializer.sv
// Holds finished character strings and sends them one beat per character.
// Depends on sbda_pkg and the assertion macro header.
`default_nettype none
`include "signed_binary_to_decimal_ascii_assert.svh"

module sbda_serializer import sbda_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire stage_t            data_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_char_o,
  output logic [CNT_W-1:0]       out_cnt_o,
  output logic                   out_stream_o,
  output logic                   out_last_o
);

  // Pending string and the string being sent.
  logic                      pvalid_q, pvalid_d;
  stage_t                    pbuf_q;
  logic [MAX_CHARS-1:0][7:0] abuf_q, abuf_d;
  logic [CNT_W-1:0]          arem_q, arem_d;
  logic [CNT_W-1:0]          acnt_q, acnt_d;
  logic                      astream_q, astream_d;
  logic                      avalid;
  logic                      pop;
  logic                      afree;
  logic                      move;

  assign avalid = (arem_q != '0);
  assign pop    = avalid && out_ready_i;
  assign afree  = !avalid || (pop && (arem_q == CNT_W'(1)));
  assign move   = afree && pvalid_q;

  // Shift on each beat; reload from the pending string when a run ends.
  always_comb begin
    abuf_d    = abuf_q;
    arem_d    = arem_q;
    acnt_d    = acnt_q;
    astream_d = astream_q;
    pvalid_d  = pvalid_q;
    if (pop) begin
      abuf_d = {8'd0, abuf_q[MAX_CHARS-1:1]};
      arem_d = arem_q - CNT_W'(1);
      acnt_d = acnt_q + CNT_W'(1);
    end
    if (move) begin
      abuf_d    = pbuf_q.chars;
      arem_d    = pbuf_q.n;
      acnt_d    = CNT_W'(1);
      astream_d = pbuf_q.stream;
      pvalid_d  = 1'b0;
    end
    if (load_i) begin
      pvalid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
      arem_q   <= '0;
    end else begin
      pvalid_q <= pvalid_d;
      arem_q   <= arem_d;
    end
  end

  // Character payload.
  always_ff @(posedge clk_i) begin
    abuf_q    <= abuf_d;
    acnt_q    <= acnt_d;
    astream_q <= astream_d;
    if (load_i) begin
      pbuf_q <= data_i;
    end
  end

  assign ready_o      = !pvalid_q;
  assign out_valid_o  = avalid;
  assign out_char_o   = abuf_q[0];
  assign out_cnt_o    = acnt_q;
  assign out_stream_o = astream_q;
  assign out_last_o   = (arem_q == CNT_W'(1));

  `SBDA_ASSERT(load_only_when_free_a, clk_i, rst_ni, load_i |-> !pvalid_q, "load into full slot")
  `SBDA_ASSERT_NEXT(run_continues_a, clk_i, rst_ni, pop && (arem_q > CNT_W'(1)), avalid, "run cut short")
  `SBDA_ASSERT_NEXT(count_restarts_a, clk_i, rst_ni, pop && out_last_o && pvalid_q, acnt_q == CNT_W'(1), "count not restarted")

endmodule

`default_nettype wire

### sv/signed_binary_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII, one character per output beat.
// Path of the first character: sign stage, ten digit cells, pending slot,
// output register.
// Throughput is set by the output serializer; the cell chain takes a new
// number every cycle unless its tail is blocked by a full pending slot.
// Reset: asynchronous, active low; clears all valid bits, no clearing pass.
`default_nettype none

module signed_binary_to_decimal_ascii import sbda_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // value[31:0]
  input  wire logic        s_axis_tuser,  // to_error_stream[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // char_code[7:0], char_count[11:8], zero[15:12]
  output logic             m_axis_tuser,  // to_error_stream_res[0]
  output logic             m_axis_tlast
);

  wire logic            chain_valid [MAG_DIGITS+1];
  wire stage_t          chain_data  [MAG_DIGITS+1];
  logic                 ent_valid_q;
  stage_t               ent_q;
  stage_t               ent_d;
  logic                 en;
  logic                 ser_ready;
  logic                 load;
  logic [7:0]           out_char;
  logic [CNT_W-1:0]     out_cnt;

  // The whole chain moves unless its tail is blocked by a full pending slot.
  assign en            = !chain_valid[MAG_DIGITS] || ser_ready;
  assign load          = chain_valid[MAG_DIGITS] && ser_ready;
  assign s_axis_tready = en;

  // Sign stage: magnitude and an optional leading minus.
  always_comb begin
    ent_d        = '0;
    ent_d.stream = s_axis_tuser;
    ent_d.rest   = s_axis_tdata;
    if (s_axis_tdata[31]) begin
      ent_d.rest     = 32'd0 - s_axis_tdata;
      ent_d.n        = CNT_W'(1);
      ent_d.chars[0] = CH_MINUS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
    end else if (en) begin
      ent_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q <= ent_d;
    end
  end

  assign chain_valid[0] = ent_valid_q;
  assign chain_data[0]  = ent_q;

  // Digit cells, highest decimal position first.
  for (genvar g = 0; g < MAG_DIGITS; g++) begin : g_cell
    sbda_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .pos_i   (POS_W'(MAG_DIGITS - 1 - g)),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  // Output side.
  sbda_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .data_i       (chain_data[MAG_DIGITS]),
    .ready_o      (ser_ready),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (out_char),
    .out_cnt_o    (out_cnt),
    .out_stream_o (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {{(16 - 8 - CNT_W){1'b0}}, out_cnt, out_char};

endmodule

`default_nettype wire
